// ===== design/mevp_pkg.sv =====
package mevp_pkg;

    localparam int VOICE_COUNT = 16;
    localparam int VOICE_W = $clog2(VOICE_COUNT);
    localparam int MAX_RESULTS = 16;

    localparam logic [1:0] CMD_SPAWN = 2'd0;
    localparam logic [1:0] CMD_TICK = 2'd1;
    localparam logic [1:0] CMD_FLUSH_CHAN = 2'd2;
    localparam logic [1:0] CMD_FLUSH_ALL = 2'd3;

    localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;
    localparam logic [3:0] STATUS_NOTE_ON = 4'h9;
    localparam logic [6:0] NOTE_MAX = 7'd127;

    typedef struct packed {
        logic [1:0] command;
        logic [3:0] song_channel;
        logic [3:0] midi_channel;
        logic [6:0] note;
        logic [6:0] velocity;
        logic [7:0] repeat_count;
        logic [7:0] interval_ticks;
        logic signed [7:0] semitone_step;
        logic [7:0] gate_ticks;
    } req_t;

    typedef struct packed {
        logic [7:0] status_byte;
        logic [6:0] note_out;
        logic [6:0] velocity_out;
        logic last;
    } msg_t;

    // One voice record as held in the voice memory.
    typedef struct packed {
        logic [3:0] song_channel;
        logic [3:0] midi_channel;
        logic [6:0] note;
        logic [6:0] velocity;
        logic [6:0] start_velocity;
        logic [7:0] repeats_left;
        logic [7:0] repeats_total;
        logic [7:0] interval;
        logic [7:0] wait_left;
        logic [7:0] transpose;
        logic [7:0] gate_length;
        logic [7:0] gate_left;
    } voice_t;

endpackage

// ===== design/mevp_req_if.sv =====
interface mevp_req_if;
    import mevp_pkg::*;
    logic valid;
    logic ready;
    req_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== design/mevp_msg_if.sv =====
interface mevp_msg_if;
    import mevp_pkg::*;
    logic valid;
    logic ready;
    msg_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== design/midi_echo_voice_pool.sv =====
// Echo voice pool: voice records live in one synchronous memory with a
// registered read port, and the active flags in flip-flops. A spawn is taken
// in its acceptance cycle, so the next request can follow straight away. A
// tick or flush walks every voice in order through a read, update and
// write-back sequencer. An inactive voice passes only through the read and
// advance steps, an active voice through read, update, emit, write-back and
// advance, and a voice that starts an echo with a further echo to come also
// waits in a divide step, because its next velocity comes from a one-bit-a-
// cycle divider. The walk also waits while the receiver stalls. Each message
// is held back until the next one or the end of the walk, so that the last
// one can be marked, and then waits in an output register until taken; no
// new request is accepted while that register is full.
module midi_echo_voice_pool (
    input  logic clk,
    input  logic rst_n,
    mevp_req_if.sink   req,
    mevp_msg_if.source msg
);
    import mevp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_EVAL, S_DIV, S_EMIT, S_WRITE, S_NEXT
    } state_t;

    voice_t voice_mem [VOICE_COUNT];
    voice_t rd_reg;
    voice_t vc_reg, vc_next;

    state_t state_reg;
    logic [VOICE_COUNT-1:0] active_reg;
    logic [VOICE_W-1:0] idx_reg;
    req_t cmd_reg;
    logic msg_valid_reg;
    msg_t msg_reg, pend_reg, cand_reg;
    logic pend_reg_valid;
    logic emitted_reg;
    logic [4:0] count_reg;
    logic keep_reg;
    logic need_div_reg;

    logic div_start, div_done;
    logic [14:0] div_quot;
    logic [14:0] div_dividend;

    // Spawn target: lowest free voice.
    logic [VOICE_W-1:0] free_idx;
    logic free_found;
    always_comb
    begin
        free_idx = '0;
        free_found = 1'b0;
        for (int i = VOICE_COUNT - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_idx = VOICE_W'(i);
                free_found = 1'b1;
            end
        end
    end

    assign req.ready = (state_reg == S_IDLE) && !msg_valid_reg;
    assign msg.valid = msg_valid_reg;
    assign msg.payload = msg_reg;

    logic spawn_take;
    assign spawn_take = req.valid && req.ready && (req.payload.command == CMD_SPAWN)
                        && (req.payload.repeat_count != 8'd0) && free_found;

    logic last_voice;
    assign last_voice = (idx_reg == VOICE_W'(VOICE_COUNT - 1));

    assign div_dividend = 15'(vc_reg.start_velocity) * 15'(vc_reg.repeats_left);
    assign div_start = (state_reg == S_DIV) && need_div_reg;

    mevp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (vc_reg.repeats_total),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Per-voice update for tick and flush; result is a candidate message.
    logic evt_emit, evt_keep, evt_div;
    msg_t evt_msg;
    logic signed [8:0] nsum;
    always_comb
    begin
        vc_next = rd_reg;
        evt_emit = 1'b0;
        evt_keep = 1'b1;
        evt_div = 1'b0;
        evt_msg = '0;
        nsum = $signed({2'b00, rd_reg.note}) + 9'(signed'(rd_reg.transpose));
        if (cmd_reg.command == CMD_TICK)
        begin
            if (rd_reg.gate_left != 8'd0)
            begin
                vc_next.gate_left = rd_reg.gate_left - 8'd1;
                if (rd_reg.gate_left == 8'd1)
                begin
                    evt_emit = 1'b1;
                    evt_msg = '{{STATUS_NOTE_OFF, rd_reg.midi_channel}, rd_reg.note, 7'd0,
                                1'b0};
                    if (rd_reg.repeats_left == 8'd0)
                    begin
                        evt_keep = 1'b0;
                    end
                    else
                    begin
                        vc_next.wait_left = rd_reg.interval;
                    end
                end
            end
            else if (rd_reg.wait_left > 8'd1)
            begin
                vc_next.wait_left = rd_reg.wait_left - 8'd1;
            end
            else
            begin
                vc_next.wait_left = 8'd0;
                if (rd_reg.repeats_left == 8'd0)
                begin
                    evt_keep = 1'b0;
                end
                else
                begin
                    evt_emit = 1'b1;
                    evt_msg = '{{STATUS_NOTE_ON, rd_reg.midi_channel}, rd_reg.note,
                                rd_reg.velocity, 1'b0};
                    vc_next.repeats_left = rd_reg.repeats_left - 8'd1;
                    vc_next.gate_left = rd_reg.gate_length;
                    if (rd_reg.repeats_left != 8'd1)
                    begin
                        if (nsum < 0)
                        begin
                            vc_next.note = 7'd0;
                        end
                        else if (nsum > 9'sd127)
                        begin
                            vc_next.note = NOTE_MAX;
                        end
                        else
                        begin
                            vc_next.note = nsum[6:0];
                        end
                        evt_div = 1'b1;
                    end
                end
            end
        end
        else if ((cmd_reg.command == CMD_FLUSH_ALL)
                 || (rd_reg.song_channel == cmd_reg.song_channel))
        begin
            evt_keep = 1'b0;
            if (rd_reg.gate_left != 8'd0)
            begin
                evt_emit = 1'b1;
                evt_msg = '{{STATUS_NOTE_OFF, rd_reg.midi_channel}, rd_reg.note, 7'd0, 1'b0};
            end
        end
    end

    logic [6:0] scaled_vel;
    always_comb
    begin
        if (div_quot == 15'd0)
        begin
            scaled_vel = 7'd1;
        end
        else if (div_quot > 15'd127)
        begin
            scaled_vel = NOTE_MAX;
        end
        else
        begin
            scaled_vel = div_quot[6:0];
        end
    end

    // The held message goes out when the next one arrives or the walk ends.
    logic take;
    logic out_free, out_load;
    msg_t out_msg;
    assign take = emitted_reg && (count_reg < 5'(MAX_RESULTS));
    always_comb
    begin
        out_free = !msg_valid_reg || msg.ready;
        out_load = pend_reg_valid && out_free
                   && (((state_reg == S_EMIT) && take) || ((state_reg == S_NEXT) && last_voice));
        out_msg = pend_reg;
        out_msg.last = (state_reg == S_NEXT);
    end

    always_ff @(posedge clk)
    begin
        rd_reg <= voice_mem[idx_reg];
        if (spawn_take)
        begin
            voice_mem[free_idx] <= '{
                req.payload.song_channel, req.payload.midi_channel,
                req.payload.note, req.payload.velocity, req.payload.velocity,
                req.payload.repeat_count, req.payload.repeat_count,
                (req.payload.interval_ticks == 8'd0) ? 8'd1 : req.payload.interval_ticks,
                (req.payload.interval_ticks == 8'd0) ? 8'd1 : req.payload.interval_ticks,
                req.payload.semitone_step,
                (req.payload.gate_ticks == 8'd0) ? 8'd1 : req.payload.gate_ticks,
                8'd0};
        end
        else if (state_reg == S_WRITE && keep_reg)
        begin
            voice_mem[idx_reg] <= vc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            active_reg <= '0;
            idx_reg <= '0;
            msg_valid_reg <= 1'b0;
            pend_reg_valid <= 1'b0;
            emitted_reg <= 1'b0;
            count_reg <= '0;
            keep_reg <= 1'b0;
            need_div_reg <= 1'b0;
            cmd_reg <= '0;
            msg_reg <= '0;
            pend_reg <= '0;
            cand_reg <= '0;
            vc_reg <= '0;
        end
        else
        begin
            if (out_load)
            begin
                msg_reg <= out_msg;
                msg_valid_reg <= 1'b1;
            end
            else if (msg.ready)
            begin
                msg_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid && req.ready)
                    begin
                        cmd_reg <= req.payload;
                        if (req.payload.command == CMD_SPAWN)
                        begin
                            if (spawn_take)
                            begin
                                active_reg[free_idx] <= 1'b1;
                            end
                        end
                        else
                        begin
                            idx_reg <= '0;
                            count_reg <= '0;
                            pend_reg_valid <= 1'b0;
                            state_reg <= S_READ;
                        end
                    end
                end
                S_READ:
                begin
                    if (active_reg[idx_reg])
                    begin
                        state_reg <= S_EVAL;
                    end
                    else
                    begin
                        state_reg <= S_NEXT;
                    end
                end
                S_EVAL:
                begin
                    vc_reg <= vc_next;
                    keep_reg <= evt_keep;
                    need_div_reg <= evt_div;
                    emitted_reg <= evt_emit;
                    if (evt_emit)
                    begin
                        cand_reg <= evt_msg;
                    end
                    state_reg <= evt_div ? S_DIV : S_EMIT;
                end
                S_DIV:
                begin
                    if (need_div_reg)
                    begin
                        need_div_reg <= 1'b0;
                    end
                    else if (div_done)
                    begin
                        vc_reg.velocity <= (vc_reg.repeats_total == 8'd0) ? 7'd1 : scaled_vel;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (!take)
                    begin
                        state_reg <= S_WRITE;
                    end
                    else if (!pend_reg_valid)
                    begin
                        pend_reg <= cand_reg;
                        pend_reg_valid <= 1'b1;
                        count_reg <= count_reg + 5'd1;
                        state_reg <= S_WRITE;
                    end
                    else if (out_free)
                    begin
                        pend_reg <= cand_reg;
                        count_reg <= count_reg + 5'd1;
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    active_reg[idx_reg] <= keep_reg;
                    state_reg <= S_NEXT;
                end
                S_NEXT:
                begin
                    if (last_voice)
                    begin
                        if (!pend_reg_valid)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else if (out_free)
                        begin
                            pend_reg_valid <= 1'b0;
                            state_reg <= S_IDLE;
                        end
                    end
                    else
                    begin
                        idx_reg <= idx_reg + VOICE_W'(1);
                        state_reg <= S_READ;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> (state_reg == S_IDLE))
        else $error("ready outside idle");
    a_msg_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (msg.valid && !msg.ready) |=> (msg.valid && $stable(msg.payload)))
        else $error("message dropped while stalled");
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (count_reg <= 5'(MAX_RESULTS)))
        else $error("too many messages");
`endif
endmodule

// ===== design/mevp_div.sv =====
// Restoring divider, one quotient bit per cycle: 15-bit dividend by 8-bit divisor.
module mevp_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [14:0] dividend,
    input  logic [7:0]  divisor,
    output logic        done,
    output logic [14:0] quotient
);
    import mevp_pkg::*;

    logic [14:0] quot_reg;
    logic [8:0]  rem_reg;
    logic [7:0]  dvs_reg;
    logic [3:0]  count_reg;
    logic        busy_reg;
    logic [9:0]  trial;
    logic [8:0]  shifted;

    assign shifted = {rem_reg[7:0], quot_reg[14]};
    assign trial = {1'b0, shifted} - {2'b00, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            count_reg <= 4'd0;
        end
        else if (busy_reg)
        begin
            count_reg <= count_reg + 4'd1;
            if (count_reg == 4'd14)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[9])
            begin
                rem_reg  <= trial[8:0];
                quot_reg <= {quot_reg[13:0], 1'b1};
            end
            else
            begin
                rem_reg  <= shifted;
                quot_reg <= {quot_reg[13:0], 1'b0};
            end
        end
    end

    assign done = busy_reg && (count_reg == 4'd14);
    assign quotient = {quot_reg[13:0], ~trial[9]};
endmodule
